@@ sv/cpio_newc_file_locator_top_macros.svh @@
// ----------------------------------------------------------------------------
// cpio newc file locator assertion macros
// shared concurrent assertion forms, clocked on clk_i and quiet in reset
// ----------------------------------------------------------------------------
`ifndef CPIO_NEWC_FILE_LOCATOR_TOP_MACROS_SVH
`define CPIO_NEWC_FILE_LOCATOR_TOP_MACROS_SVH

// consequent holds in the same cycle
`define CFL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the next cycle
`define CFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/cfl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfl_pkg
// types and constants shared by the cpio newc file locator modules
// ----------------------------------------------------------------------------
package cfl_pkg;

  typedef logic [32:0] cnt_t;

  localparam int NameChars = 8;
  localparam int WinIdxW   = 3;

  localparam cnt_t HdrLast    = cnt_t'(109);
  localparam cnt_t FsizeFirst = cnt_t'(54);
  localparam cnt_t FsizeEnd   = cnt_t'(62);
  localparam cnt_t NsizeFirst = cnt_t'(94);
  localparam cnt_t NsizeEnd   = cnt_t'(102);

  localparam logic [3:0] LenMax = 4'd8;
  localparam logic [7:0] Slash  = 8'h2f;

  localparam logic [1:0] RegTargetName   = 2'd0;
  localparam logic [1:0] RegTargetLength = 2'd1;

  typedef enum logic [1:0] {
    PhHeader = 2'd0,
    PhName   = 2'd1,
    PhData   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    StFound     = 2'd0,
    StZeroName  = 2'd1,
    StEnded     = 2'd2,
    StMalformed = 2'd3
  } status_e;

  typedef struct packed {
    logic clear;
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic decided;
    logic result;
  } cmp_carry_t;

  typedef struct packed {
    logic [31:0] file_size;
    logic [31:0] data_offset;
    status_e     status;
  } result_t;

endpackage

@@ sv/cfl_name_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfl_name_cell
// one byte of the name window with its step of the string compare chain
// ----------------------------------------------------------------------------
module cfl_name_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfl_pkg::cell_ctrl_t    ctrl_i,
  input  logic [7:0]             load_byte_i,
  input  logic [7:0]             shift_byte_i,
  input  logic [7:0]             tgt_byte_i,
  input  logic                   active_i,
  input  cfl_pkg::cmp_carry_t    carry_i,
  output logic [7:0]             byte_o,
  output cfl_pkg::cmp_carry_t    carry_o
);

  logic [7:0] win_q, win_d, win_upd;

  always_comb begin
    priority if (ctrl_i.load) begin
      win_upd = load_byte_i;
    end else if (ctrl_i.shift) begin
      win_upd = shift_byte_i;
    end else begin
      win_upd = win_q;
    end
    win_d = ctrl_i.clear ? 8'd0 : win_upd;
  end

  always_comb begin
    carry_o = carry_i;
    if (!carry_i.decided && active_i) begin
      if (win_upd != tgt_byte_i) begin
        carry_o.decided = 1'b1;
        carry_o.result  = 1'b0;
      end else if (win_upd == 8'd0) begin
        carry_o.decided = 1'b1;
        carry_o.result  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= 8'd0;
    end else begin
      win_q <= win_d;
    end
  end

  assign byte_o = win_q;

endmodule

@@ sv/cfl_skid.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfl_skid
// two-entry result buffer between the parser and the result stream
// ----------------------------------------------------------------------------
module cfl_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  cfl_pkg::result_t    in_data_i,
  output logic                space_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cfl_pkg::result_t    out_data_o
);

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  cfl_pkg::result_t out_q, out_d;
  cfl_pkg::result_t skid_q, skid_d;
  logic             out_fire;

  assign out_fire = out_valid_q & out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (in_valid_i) begin
      if (!out_valid_q || out_fire) begin
        out_d       = in_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = in_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign space_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sv/cpio_newc_file_locator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpio_newc_file_locator_top
// walks a cpio newc archive byte by byte and reports where the named file is
// ----------------------------------------------------------------------------
// One archive byte is taken per clock whenever s_axis_tready is high, with no gaps
// between entries. The result of a byte is registered into a two-entry output
// buffer on the master side after its transfer; s_axis_tready drops only
// while both entries hold untaken results. The name compare runs through a row
// of eight byte cells, one per target character, in the cycle of the last byte
// of the padded name region. After a result the stream is drained until tlast
// rearms the parser. No clearing pass is needed after reset.
module cpio_newc_file_locator_top #(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // archive_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // data_offset [31:0], file_size [63:32]
  output logic [1:0]  m_axis_tuser    // status
);

  logic [63:0] tname_q;
  logic [3:0]  tlen_q;

  cfl_pkg::phase_e       phase_q, phase_d;
  cfl_pkg::cnt_t         cnt_q, cnt_d, cnt_inc;
  logic [31:0]           name_size_q, name_size_d;
  logic [31:0]           data_size_q, data_size_d;
  logic [OFFSET_BITS:0]  off_q, off_d;
  cfl_pkg::cnt_t         name_reg_q, dlen_q;
  logic                  prefix_q, prefix_d;
  logic                  done_q, done_d;

  logic                  s_fire;
  logic                  space;
  logic                  res_valid;
  cfl_pkg::result_t      res;
  cfl_pkg::result_t      m_data;
  logic                  win_clear, win_shift, win_load;
  logic [4:0]            hex;
  logic                  in_fs, in_ns;
  logic                  size_ok, chain_ok;
  logic [3:0]            len_eff;
  logic [OFFSET_BITS-1:0] doff;
  logic [OFFSET_BITS+31:0] doff_ext;

  logic [7:0]            win [cfl_pkg::NameChars];
  logic [7:0]            cell_tgt [cfl_pkg::NameChars];
  logic [2:0]            cell_idx [cfl_pkg::NameChars];
  logic                  cell_active [cfl_pkg::NameChars];
  cfl_pkg::cmp_carry_t   carry [cfl_pkg::NameChars+1];

  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tname_q <= 64'd0;
      tlen_q  <= 4'd4;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == cfl_pkg::RegTargetName) begin
        tname_q <= cfg_data_i;
      end else if (cfg_idx_i == cfl_pkg::RegTargetLength) begin
        tlen_q <= cfg_data_i[3:0];
      end
    end
  end

  assign len_eff = (tlen_q > cfl_pkg::LenMax) ? cfl_pkg::LenMax : tlen_q;
  assign s_fire  = s_axis_tvalid & s_axis_tready;
  assign cnt_inc = cnt_q + cfl_pkg::cnt_t'(1);
  assign hex     = hex_digit(s_axis_tdata);
  assign in_fs   = (cnt_q >= cfl_pkg::FsizeFirst) && (cnt_q < cfl_pkg::FsizeEnd);
  assign in_ns   = (cnt_q >= cfl_pkg::NsizeFirst) && (cnt_q < cfl_pkg::NsizeEnd);
  assign size_ok = prefix_q ? ({1'b0, name_size_q} >= cfl_pkg::cnt_t'(len_eff))
                            : ({1'b0, name_size_q} >= cfl_pkg::cnt_t'(len_eff) +
                               cfl_pkg::cnt_t'(1));
  assign chain_ok = !carry[cfl_pkg::NameChars].decided ||
                    carry[cfl_pkg::NameChars].result;
  assign doff     = off_q[OFFSET_BITS-1:0] + OFFSET_BITS'(1);
  assign doff_ext = {32'd0, doff};

  // name window cell row
  assign carry[0] = '0;
  for (genvar j = 0; j < cfl_pkg::NameChars; j++) begin : g_cell
    logic [3:0]          sum;
    logic [7:0]          shift_src;
    cfl_pkg::cell_ctrl_t ctrl;

    assign sum            = 4'(j) + len_eff;
    assign cell_active[j] = prefix_q ? (4'(j) < len_eff) : sum[3];
    assign cell_idx[j]    = prefix_q ? 3'(j) : sum[2:0];
    assign cell_tgt[j]    = tname_q[8*cell_idx[j] +: 8];

    if (j == cfl_pkg::NameChars - 1) begin : g_end
      assign shift_src = s_axis_tdata;
    end else begin : g_mid
      assign shift_src = win[j+1];
    end

    assign ctrl.clear = win_clear;
    assign ctrl.shift = win_shift;
    assign ctrl.load  = win_load && (cnt_q[cfl_pkg::WinIdxW-1:0] == 3'(j));

    cfl_name_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .load_byte_i (s_axis_tdata),
      .shift_byte_i(shift_src),
      .tgt_byte_i  (cell_tgt[j]),
      .active_i    (cell_active[j]),
      .carry_i     (carry[j]),
      .byte_o      (win[j]),
      .carry_o     (carry[j+1])
    );
  end

  // parser step
  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    name_size_d = name_size_q;
    data_size_d = data_size_q;
    off_d       = off_q;
    prefix_d    = prefix_q;
    done_d      = done_q;
    res_valid   = 1'b0;
    res         = '0;
    win_clear   = 1'b0;
    win_shift   = 1'b0;
    win_load    = 1'b0;
    if (s_fire) begin
      if (!done_q) begin
        if (off_q[OFFSET_BITS]) begin
          res_valid  = 1'b1;
          res.status = cfl_pkg::StMalformed;
          done_d     = 1'b1;
        end else begin
          unique case (phase_q)
            cfl_pkg::PhHeader: begin
              if ((in_fs || in_ns) && !hex[4]) begin
                res_valid  = 1'b1;
                res.status = cfl_pkg::StMalformed;
                done_d     = 1'b1;
              end else begin
                if (in_fs) begin
                  data_size_d = (cnt_q == cfl_pkg::FsizeFirst) ? {28'd0, hex[3:0]}
                                                               : {data_size_q[27:0], hex[3:0]};
                end
                if (in_ns) begin
                  name_size_d = (cnt_q == cfl_pkg::NsizeFirst) ? {28'd0, hex[3:0]}
                                                               : {name_size_q[27:0], hex[3:0]};
                end
                if (cnt_q >= cfl_pkg::HdrLast) begin
                  if (name_size_q == 32'd0) begin
                    res_valid  = 1'b1;
                    res.status = cfl_pkg::StZeroName;
                    done_d     = 1'b1;
                  end else begin
                    phase_d   = cfl_pkg::PhName;
                    cnt_d     = '0;
                    prefix_d  = (tname_q[7:0] == cfl_pkg::Slash);
                    win_clear = 1'b1;
                  end
                end else begin
                  cnt_d = cnt_inc;
                end
              end
            end
            cfl_pkg::PhName: begin
              if (prefix_q) begin
                win_load = (cnt_q < cfl_pkg::cnt_t'(cfl_pkg::NameChars));
              end else begin
                win_shift = (cnt_inc < {1'b0, name_size_q});
              end
              if (cnt_inc >= name_reg_q) begin
                if (size_ok && chain_ok) begin
                  res_valid = 1'b1;
                  done_d    = 1'b1;
                  if (&off_q[OFFSET_BITS-1:0]) begin
                    res.status = cfl_pkg::StMalformed;
                  end else begin
                    res.status      = cfl_pkg::StFound;
                    res.data_offset = doff_ext[31:0];
                    res.file_size   = data_size_q;
                  end
                end else begin
                  phase_d = (data_size_q != 32'd0) ? cfl_pkg::PhData : cfl_pkg::PhHeader;
                  cnt_d   = '0;
                end
              end else begin
                cnt_d = cnt_inc;
              end
            end
            default: begin
              if (cnt_inc >= dlen_q) begin
                phase_d = cfl_pkg::PhHeader;
                cnt_d   = '0;
              end else begin
                cnt_d = cnt_inc;
              end
            end
          endcase
        end
        if (!off_q[OFFSET_BITS]) begin
          off_d = off_q + (OFFSET_BITS+1)'(1);
        end
      end
      if (s_axis_tlast) begin
        if (!res_valid && !done_d) begin
          res_valid  = 1'b1;
          res.status = cfl_pkg::StEnded;
        end
        phase_d     = cfl_pkg::PhHeader;
        cnt_d       = '0;
        name_size_d = 32'd0;
        data_size_d = 32'd0;
        off_d       = '0;
        prefix_d    = 1'b1;
        done_d      = 1'b0;
        win_clear   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= cfl_pkg::PhHeader;
      cnt_q       <= '0;
      name_size_q <= 32'd0;
      data_size_q <= 32'd0;
      off_q       <= '0;
      prefix_q    <= 1'b1;
      done_q      <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      name_size_q <= name_size_d;
      data_size_q <= data_size_d;
      off_q       <= off_d;
      prefix_q    <= prefix_d;
      done_q      <= done_d;
    end
  end

  // name region and padded data length, settled well before they are used
  always_ff @(posedge clk_i) begin
    name_reg_q <= {1'b0, name_size_q} + cfl_pkg::cnt_t'(2'(2'd2 - name_size_q[1:0]));
    dlen_q     <= {1'b0, data_size_q} + cfl_pkg::cnt_t'(2'(2'd0 - data_size_q[1:0]));
  end

  cfl_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (res_valid),
    .in_data_i  (res),
    .space_o    (space),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_data)
  );

  assign s_axis_tready = space;
  assign m_axis_tdata  = {m_data.file_size, m_data.data_offset};
  assign m_axis_tuser  = m_data.status;

`include "cpio_newc_file_locator_top_macros.svh"

  `CFL_ASSERT_NEXT(a_done_hold, done_q && !(s_fire && s_axis_tlast), done_q, "search left done state without last transfer")
  `CFL_ASSERT_SAME(a_hdr_range, phase_q == cfl_pkg::PhHeader, cnt_q <= cfl_pkg::HdrLast, "header count beyond header")
  `CFL_ASSERT_SAME(a_found_name, res_valid && res.status == cfl_pkg::StFound, phase_q == cfl_pkg::PhName && !done_q, "match reported outside name region")
  `CFL_ASSERT_NEXT(a_off_sat, off_q[OFFSET_BITS] && !(s_fire && s_axis_tlast), off_q[OFFSET_BITS], "offset counter left saturation")

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the cpio newc file locator against its own cycle-free model
// ----------------------------------------------------------------------------
// Archive bytes are fed one per transfer from a queue, with random sender gaps
// and receiver stalls. Each accepted byte is run through a byte-level model of
// the locator, and any result it gives is held until the block's result
// transfer arrives. Then status, data offset and file size are compared. Both
// target registers are rewritten between archives, while the block is idle.
// The run starts with directed archives, then has a stretch in which the
// receiver holds off, then random archives, most of them well formed.
// ----------------------------------------------------------------------------
module tb;

  localparam int          StallLimit    = 2000;
  localparam int          HoldOffCycles = 150;
  localparam int          HeaderLen     = 110;
  localparam int          FsizeAt       = 54;
  localparam int          NsizeAt       = 94;
  localparam logic [63:0] OffsetMask    = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } arc_byte_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = cfl_pkg::RegTargetName;
  logic [63:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // archive_byte
  logic        s_axis_tlast  = 1'b0; // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;         // data_offset [31:0], file_size [63:32]
  logic [1:0]  m_axis_tuser;         // status

  arc_byte_t          pending_bytes[$];
  cfl_pkg::result_t   predicted_results[$];

  int mismatches    = 0;
  int items_random  = 0;
  int quiet_cycles  = 0;
  int tx_gap        = 0;
  int rx_wait       = 0;
  int rx_hold       = 0;
  logic tx_gaps_on  = 1'b0;
  logic rx_gaps_on  = 1'b0;
  logic hold_off_req = 1'b0;
  logic s_took      = 1'b0;
  arc_byte_t tx_item;
  cfl_pkg::result_t mon_want;

  // model copy of the target registers and of the parser state
  logic [63:0]     tgt_name = '0;
  logic [3:0]      tgt_len  = 4'd4;
  cfl_pkg::phase_e lc_phase;
  logic [63:0]     lc_count;
  logic [63:0]     lc_offset;
  logic [31:0]     lc_nsize;
  logic [31:0]     lc_dsize;
  logic [7:0]      lc_win[cfl_pkg::NameChars];
  logic            lc_prefix;
  logic            lc_done;

  cpio_newc_file_locator_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  function automatic void clear_locator();
    int i;
    lc_phase  = cfl_pkg::PhHeader;
    lc_count  = '0;
    lc_offset = '0;
    lc_nsize  = '0;
    lc_dsize  = '0;
    for (i = 0; i < cfl_pkg::NameChars; i++) lc_win[i] = 8'h00;
    lc_prefix = 1'b1;
    lc_done   = 1'b0;
  endfunction

  function automatic int hex_digit(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
    if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
    if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
    return -1;
  endfunction

  function automatic logic name_hit();
    int len;
    int base;
    int i;
    logic [7:0] a;
    logic [7:0] t;
    len  = (tgt_len > cfl_pkg::LenMax) ? cfl_pkg::NameChars : int'(tgt_len);
    base = 0;
    if (lc_prefix) begin
      if ({32'd0, lc_nsize} < len) return 1'b0;
    end else begin
      if ({32'd0, lc_nsize} < len + 1) return 1'b0;
      base = cfl_pkg::NameChars - len;
    end
    for (i = 0; i < len; i++) begin
      a = lc_win[(base + i) % cfl_pkg::NameChars];
      t = tgt_name[8*i +: 8];
      if (a != t) return 1'b0;
      if (a == 8'h00) return 1'b1;
    end
    return 1'b1;
  endfunction

  // advances the parser model by one byte; returns 1 when a result is due
  function automatic logic locate_step(input logic [7:0] b, input logic last,
                                       output cfl_pkg::result_t res);
    logic hit;
    logic [63:0] p;
    logic [63:0] dlen;
    logic [63:0] nreg;
    logic [63:0] doff;
    int d;
    int i;
    hit = 1'b0;
    res = '0;
    if (!lc_done) begin
      if (lc_offset > OffsetMask) begin
        res.status = cfl_pkg::StMalformed;
        hit = 1'b1;
        lc_done = 1'b1;
      end else begin
        case (lc_phase)
          cfl_pkg::PhHeader: begin
            p = lc_count;
            if ((p >= FsizeAt && p < FsizeAt + 8) || (p >= NsizeAt && p < NsizeAt + 8)) begin
              d = hex_digit(b);
              if (d < 0) begin
                res.status = cfl_pkg::StMalformed;
                hit = 1'b1;
                lc_done = 1'b1;
              end else if (p < FsizeAt + 8) begin
                lc_dsize = ((p == FsizeAt) ? 32'd0 : (lc_dsize << 4)) | 32'(d);
              end else begin
                lc_nsize = ((p == NsizeAt) ? 32'd0 : (lc_nsize << 4)) | 32'(d);
              end
            end
            if (!lc_done) begin
              if (p + 1 >= HeaderLen) begin
                if (lc_nsize == 0) begin
                  res.status = cfl_pkg::StZeroName;
                  hit = 1'b1;
                  lc_done = 1'b1;
                end else begin
                  lc_phase  = cfl_pkg::PhName;
                  lc_count  = '0;
                  lc_prefix = (tgt_name[7:0] == cfl_pkg::Slash);
                  for (i = 0; i < cfl_pkg::NameChars; i++) lc_win[i] = 8'h00;
                end
              end else begin
                lc_count = p + 1;
              end
            end
          end
          cfl_pkg::PhName: begin
            p = lc_count;
            if (lc_prefix) begin
              if (p < cfl_pkg::NameChars) lc_win[p[2:0]] = b;
            end else if (p + 1 < {32'd0, lc_nsize}) begin
              for (i = 0; i < cfl_pkg::NameChars - 1; i++) lc_win[i] = lc_win[i+1];
              lc_win[cfl_pkg::NameChars-1] = b;
            end
            nreg = ((HeaderLen + {32'd0, lc_nsize} + 3) & ~64'd3) - HeaderLen;
            if (p + 1 >= nreg) begin
              if (name_hit()) begin
                doff = lc_offset + 1;
                if (doff > OffsetMask) begin
                  res.status = cfl_pkg::StMalformed;
                end else begin
                  res.status      = cfl_pkg::StFound;
                  res.data_offset = doff[31:0];
                  res.file_size   = lc_dsize;
                end
                hit = 1'b1;
                lc_done = 1'b1;
              end else begin
                dlen     = ({32'd0, lc_dsize} + 3) & ~64'd3;
                lc_phase = (dlen != 0) ? cfl_pkg::PhData : cfl_pkg::PhHeader;
                lc_count = '0;
              end
            end else begin
              lc_count = p + 1;
            end
          end
          default: begin
            dlen = ({32'd0, lc_dsize} + 3) & ~64'd3;
            if (lc_count + 1 >= dlen) begin
              lc_phase = cfl_pkg::PhHeader;
              lc_count = '0;
            end else begin
              lc_count = lc_count + 1;
            end
          end
        endcase
      end
      if (lc_offset <= OffsetMask) lc_offset = lc_offset + 1;
    end
    if (last) begin
      if (!hit && !lc_done) begin
        res.status = cfl_pkg::StEnded;
        hit = 1'b1;
      end
      clear_locator();
    end
    return hit;
  endfunction

  function automatic int idle_gap(input logic on);
    int r;
    r = $urandom_range(0, 99);
    if (!on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] name_char();
    int r;
    r = $urandom_range(0, 15);
    if (r < 12) begin
      case ($urandom_range(0, 3))
        0:       return 8'h61;
        1:       return 8'h62;
        2:       return cfl_pkg::Slash;
        default: return 8'h78;
      endcase
    end
    if (r < 14) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    pending_bytes.push_back('{data: b, last: last});
  endtask

  task automatic mark_last();
    arc_byte_t tail;
    tail = pending_bytes.pop_back();
    tail.last = 1'b1;
    pending_bytes.push_back(tail);
  endtask

  task automatic push_hex8(input logic [31:0] v);
    int k;
    logic [3:0] nib;
    for (k = 7; k >= 0; k--) begin
      nib = v[4*k +: 4];
      if (nib < 10) push_byte(8'h30 + 8'(nib), 1'b0);
      else push_byte(($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10, 1'b0);
    end
  endtask

  // bad_at is a header position to corrupt with a non-hex byte, or -1
  task automatic push_header(input logic [31:0] fsz, input logic [31:0] nsz,
                             input int bad_at);
    logic [47:0] magic;
    arc_byte_t hb;
    int start;
    int f;
    int r;
    magic = "070701";
    start = pending_bytes.size();
    for (f = 5; f >= 0; f--) push_byte(magic[8*f +: 8], 1'b0);
    for (f = 0; f < 13; f++) begin
      if (f == 6) push_hex8(fsz);
      else if (f == 11) push_hex8(nsz);
      else push_hex8($urandom);
    end
    if (bad_at >= 0) begin
      do r = $urandom_range(0, 255); while (hex_digit(8'(r)) >= 0);
      hb = pending_bytes[start + bad_at];
      hb.data = 8'(r);
      pending_bytes[start + bad_at] = hb;
    end
  endtask

  task automatic push_entry(input logic [7:0] nm[$], input logic [31:0] fsz,
                            input logic with_data);
    int k;
    int pad;
    push_header(fsz, nm.size(), -1);
    for (k = 0; k < nm.size(); k++) push_byte(nm[k], 1'b0);
    pad = ((HeaderLen + nm.size() + 3) & ~3) - HeaderLen - nm.size();
    repeat (pad) push_byte(8'h00, 1'b0);
    if (with_data) begin
      repeat (((fsz + 3) & ~3)) push_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic make_name(input logic want, output logic [7:0] nm[$]);
    int len;
    int k;
    len = (tgt_len > cfl_pkg::LenMax) ? cfl_pkg::NameChars : int'(tgt_len);
    nm = {};
    if (want && tgt_name[7:0] == cfl_pkg::Slash) begin
      for (k = 0; k < len; k++) nm.push_back(tgt_name[8*k +: 8]);
      repeat ($urandom_range(0, 3)) nm.push_back(name_char());
    end else if (want) begin
      repeat ($urandom_range(0, 3)) nm.push_back(name_char());
      for (k = 0; k < len; k++) nm.push_back(tgt_name[8*k +: 8]);
    end else begin
      repeat ($urandom_range(1, 10)) nm.push_back(name_char());
    end
    nm.push_back(8'h00);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [63:0] value);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == cfl_pkg::RegTargetName) tgt_name = value;
    else tgt_len = value[3:0];
  endtask

  task automatic random_target();
    logic [63:0] v;
    int k;
    if ($urandom_range(0, 9) == 0) begin
      v = {$urandom, $urandom};
    end else begin
      for (k = 0; k < 8; k++) v[8*k +: 8] = name_char();
      if ($urandom_range(0, 1)) v[7:0] = cfl_pkg::Slash;
    end
    write_cfg(cfl_pkg::RegTargetName, v);
    if ($urandom_range(0, 9) < 7) begin
      write_cfg(cfl_pkg::RegTargetLength, 64'($urandom_range(1, 8)));
    end else begin
      write_cfg(cfl_pkg::RegTargetLength, 64'($urandom_range(0, 15)));
    end
  endtask

  task automatic random_archive();
    logic [7:0] nm[$];
    logic [31:0] fsz;
    int start;
    int kind;
    int pos;
    start = pending_bytes.size();
    kind  = $urandom_range(0, 99);
    if (kind < 70) begin
      repeat ($urandom_range(1, 3)) begin
        make_name($urandom_range(0, 99) < 40, nm);
        fsz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
        push_entry(nm, fsz, 1'b1);
      end
      if ($urandom_range(0, 1)) begin
        push_header($urandom_range(0, 3), 32'd0, -1);
        repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      // cut the archive short now and then
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, pending_bytes.size() - start - 1))
          void'(pending_bytes.pop_back());
      end
    end else if (kind < 85) begin
      if ($urandom_range(0, 1)) begin
        pos = $urandom_range(0, 1) ? $urandom_range(FsizeAt, FsizeAt + 7)
                                   : $urandom_range(NsizeAt, NsizeAt + 7);
        push_header($urandom, $urandom | 32'd1, pos);
        repeat ($urandom_range(0, 5)) push_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        push_header($urandom, $urandom | 32'h8000_0000, -1);
        repeat ($urandom_range(0, 20)) push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end else begin
      repeat ($urandom_range(1, 20)) push_byte(8'($urandom_range(0, 255)), 1'b0);
    end
    mark_last();
    items_random += pending_bytes.size() - start;
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || s_axis_tvalid || predicted_results.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // sender
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && !s_took)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        tx_item = pending_bytes.pop_front();
        s_axis_tdata  <= tx_item.data;
        s_axis_tlast  <= tx_item.last;
        s_axis_tvalid <= 1'b1;
        tx_gap = idle_gap(tx_gaps_on);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
      if ($urandom_range(0, 299) == 0) tx_gaps_on = !tx_gaps_on;
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rx_hold = HoldOffCycles;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        rx_wait = idle_gap(rx_gaps_on);
      end
      if ($urandom_range(0, 299) == 0) rx_gaps_on = !rx_gaps_on;
    end
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      s_took = s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch($sformatf("result with none expected, status %0d", m_axis_tuser));
        end else begin
          mon_want = predicted_results.pop_front();
          if (m_axis_tuser !== mon_want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      m_axis_tuser, mon_want.status));
          if (m_axis_tdata[31:0] !== mon_want.data_offset)
            report_mismatch($sformatf("data_offset got %0h want %0h",
                                      m_axis_tdata[31:0], mon_want.data_offset));
          if (m_axis_tdata[63:32] !== mon_want.file_size)
            report_mismatch($sformatf("file_size got %0h want %0h",
                                      m_axis_tdata[63:32], mon_want.file_size));
        end
      end
      if (s_took) begin
        if (locate_step(s_axis_tdata, s_axis_tlast, mon_want))
          predicted_results.push_back(mon_want);
      end
      if (s_took || (m_axis_tvalid && m_axis_tready) ||
          (pending_bytes.size() == 0 && !s_axis_tvalid && predicted_results.size() == 0)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("watchdog: no transfer for %0d cycles", StallLimit);
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [7:0] nm[$];
    clear_locator();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset target: empty name, four characters, trailing match
    push_byte(8'h37, 1'b1);
    nm = '{8'h68, 8'h65, 8'h6c, 8'h6c, 8'h6f, 8'h00};
    push_entry(nm, 32'd3, 1'b1);
    push_header(32'd0, 32'd0, -1);
    mark_last();
    wait_idle();

    // leading slash target "/ab", second entry matches with an all-ones size
    write_cfg(cfl_pkg::RegTargetName, 64'h0000_0000_0062_612f);
    write_cfg(cfl_pkg::RegTargetLength, 64'd3);
    nm = '{8'h78, 8'h00};
    push_entry(nm, 32'd5, 1'b1);
    nm = '{cfl_pkg::Slash, 8'h61, 8'h62, 8'h63, 8'h00};
    push_entry(nm, 32'hFFFF_FFFF, 1'b0);
    repeat (6) push_byte(8'($urandom_range(0, 255)), 1'b0);
    mark_last();
    wait_idle();

    // trailing target "cd", match completes on the final byte
    write_cfg(cfl_pkg::RegTargetName, 64'h6463);
    write_cfg(cfl_pkg::RegTargetLength, 64'd2);
    nm = '{8'h61, 8'h62, 8'h63, 8'h64, 8'h00};
    push_entry(nm, 32'd0, 1'b0);
    mark_last();
    // bad digits in the filesize and namesize fields
    push_header(32'd12, 32'd4, FsizeAt + 3);
    repeat (3) push_byte(8'($urandom_range(0, 255)), 1'b0);
    mark_last();
    push_header(32'd12, 32'd4, NsizeAt + 7);
    mark_last();
    wait_idle();

    // zero length matches any entry
    write_cfg(cfl_pkg::RegTargetLength, 64'd0);
    nm = '{8'h78, 8'h00};
    push_entry(nm, 32'd1, 1'b1);
    mark_last();
    wait_idle();

    // all-ones target, length fifteen treated as eight
    write_cfg(cfl_pkg::RegTargetName, '1);
    write_cfg(cfl_pkg::RegTargetLength, 64'd15);
    nm = '{8'h61};
    repeat (7) nm.push_back(8'hff);
    nm.push_back(8'h00);
    push_entry(nm, 32'd2, 1'b1);
    nm = {};
    repeat (8) nm.push_back(8'hff);
    nm.push_back(8'h00);
    push_entry(nm, 32'd7, 1'b1);
    mark_last();
    // all-ones namesize, archive cut short
    push_header(32'd0, 32'hFFFF_FFFF, -1);
    repeat (5) push_byte(8'($urandom_range(0, 255)), 1'b0);
    mark_last();
    wait_idle();

    // receiver holds off while one-byte archives keep coming
    hold_off_req = 1'b1;
    repeat (30) push_byte(8'($urandom_range(0, 255)), 1'b1);
    wait_idle();

    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    while (items_random < 550) begin
      random_target();
      repeat (3) random_archive();
      wait_idle();
    end

    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
